/* design/imnl_pkg.sv */
// shared types and constants of the incidence matrix neighbour list unit
// no dependencies; imported by imnl_ctrl, imnl_datapath and the top level
package imnl_pkg;

  localparam int VERTEX_W = 6;
  localparam int EDGE_W   = 7;
  localparam int CFG_W    = 7;
  localparam int CNT_W    = 2;

  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_SELF = 2'd2;
  localparam logic [CNT_W-1:0] CNT_SAT  = 2'd3;

  localparam logic [VERTEX_W-1:0] RST_VERTEX_COUNT = 6'd32;
  localparam logic [EDGE_W-1:0]   RST_EDGE_COUNT   = 7'd64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_EDGE_COUNT   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_RD_U,
    ST_ADD_WR_U,
    ST_ADD_RD_V,
    ST_ADD_WR_V,
    ST_Q_RD_X,
    ST_Q_LOAD,
    ST_Q_SCAN,
    ST_Q_FIN
  } state_e;

  typedef enum logic [1:0] {
    RD_U,
    RD_V,
    RD_X,
    RD_SCAN
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_v;
    logic    load_qrow;
    logic    scan_step;
    logic    push_final;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic add_ok;
    logic query_ok;
    logic scan_stall;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

/* design/incidence_matrix_neighbour_list_unit.sv */
// top level of the incidence matrix neighbour list unit; depends on imnl_pkg,
// imnl_ctrl and imnl_datapath
// add-edge beat: rewrites row u, then row v, no result; ignored if out of range
// query beat: reads the queried row, then scans rows 1..n (n = vertices in use), one vertex
//   row read per cycle from the row memory while the output register can take a hit;
//   a vertex out of range gives only the final result, with found low
// one beat in flight at a time; results wait in a one-deep output register
// reset: async, active low; per-row valid bits empty the matrix at once, no clearing pass
module incidence_matrix_neighbour_list_unit #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [imnl_pkg::CFG_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [imnl_pkg::EDGE_W-1:0]   edge_index_i,
  input  logic [imnl_pkg::VERTEX_W-1:0] vertex_u_i,
  input  logic [imnl_pkg::VERTEX_W-1:0] vertex_v_i,
  input  logic [imnl_pkg::VERTEX_W-1:0] query_vertex_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [imnl_pkg::VERTEX_W-1:0] neighbour_o,
  output logic                          found_o,
  output logic                          last_o
);
  import imnl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: dispatch, read-modify-write of both end rows, or query scan
  imnl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // row memory, adjacency check and result register
  imnl_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .edge_index_i   (edge_index_i),
    .vertex_u_i     (vertex_u_i),
    .vertex_v_i     (vertex_v_i),
    .query_vertex_i (query_vertex_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .neighbour_o    (neighbour_o),
    .found_o        (found_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

/* design/imnl_ctrl.sv */
// controller state machine of the incidence matrix neighbour list unit
// depends on imnl_pkg; drives the datapath through cmd_t, watches status_t
module imnl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  imnl_pkg::status_t status_i,
  output imnl_pkg::cmd_t    cmd_o
);
  import imnl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status_i.is_query) begin
          state_d = status_i.query_ok ? ST_Q_RD_X : ST_Q_FIN;
        end else begin
          state_d = status_i.add_ok ? ST_ADD_RD_U : ST_IDLE;
        end
      end
      ST_ADD_RD_U: state_d = ST_ADD_WR_U;
      ST_ADD_WR_U: state_d = ST_ADD_RD_V;
      ST_ADD_RD_V: state_d = ST_ADD_WR_V;
      ST_ADD_WR_V: state_d = ST_IDLE;
      ST_Q_RD_X:   state_d = ST_Q_LOAD;
      ST_Q_LOAD:   state_d = ST_Q_SCAN;
      ST_Q_SCAN: begin
        if (status_i.scan_done) state_d = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = RD_U;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_ADD_RD_U: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_U;
      end
      ST_ADD_WR_U: begin
        cmd_o.wr_en = 1'b1;
      end
      ST_ADD_RD_V: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_V;
      end
      ST_ADD_WR_V: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_v  = 1'b1;
      end
      ST_Q_RD_X: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_X;
      end
      ST_Q_LOAD: begin
        cmd_o.load_qrow = 1'b1;
      end
      ST_Q_SCAN: begin
        cmd_o.rd_sel    = RD_SCAN;
        cmd_o.scan_step = !status_i.scan_done && !status_i.scan_stall;
      end
      ST_Q_FIN: begin
        cmd_o.push_final = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* design/imnl_datapath.sv */
// datapath: config registers, item registers, incidence row memory,
// adjacency check and result register; depends on imnl_pkg
module imnl_datapath #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [imnl_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          op_i,
  input  logic [imnl_pkg::EDGE_W-1:0]   edge_index_i,
  input  logic [imnl_pkg::VERTEX_W-1:0] vertex_u_i,
  input  logic [imnl_pkg::VERTEX_W-1:0] vertex_v_i,
  input  logic [imnl_pkg::VERTEX_W-1:0] query_vertex_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [imnl_pkg::VERTEX_W-1:0] neighbour_o,
  output logic                          found_o,
  output logic                          last_o,
  input  imnl_pkg::cmd_t                cmd_i,
  output imnl_pkg::status_t             status_o
);
  import imnl_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int MW = $clog2(MAX_EDGES + 1);
  localparam int PW = $clog2(MAX_VERTICES + 2);

  typedef logic [MAX_EDGES-1:0][CNT_W-1:0] row_t;

  // configuration
  logic [VERTEX_W-1:0] vcount_q;
  logic [EDGE_W-1:0]   ecount_q;
  logic                cfg_clear;
  logic [NW-1:0]       n;
  logic [MW-1:0]       m;

  // latched item
  logic                op_q;
  logic [EDGE_W-1:0]   e_q;
  logic [VERTEX_W-1:0] u_q, v_q, x_q;

  // row memory
  row_t                row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_q;
  row_t                rdata_q;
  logic                rvalid_q;
  row_t                rrow;
  row_t                wrow;
  logic [AW-1:0]       raddr, waddr;
  logic [EW-1:0]       wcol;
  logic                rd_fire;

  // scan
  row_t                qrow_q;
  logic [PW-1:0]       rd_ptr_q;
  logic                more;
  logic                chk_valid_q;
  logic [VERTEX_W-1:0] chk_vertex_q;
  logic                pend_q;
  logic [VERTEX_W-1:0] pend_vertex_q;
  logic [MAX_EDGES-1:0] hit_col;
  logic                hit;
  logic                self_chk;

  // result register
  logic                out_valid_q;
  logic [VERTEX_W-1:0] neighbour_q;
  logic                found_q, last_q;
  logic                out_free;
  logic                push_scan;

  assign cfg_clear = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= RST_VERTEX_COUNT;
      ecount_q <= RST_EDGE_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VERTEX_COUNT: vcount_q <= cfg_wdata_i[VERTEX_W-1:0];
        REG_EDGE_COUNT:   ecount_q <= cfg_wdata_i[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  // counts in use, saturated at the storage size
  always_comb begin
    n = (32'(vcount_q) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_q);
    m = (32'(ecount_q) > 32'(MAX_EDGES)) ? MW'(MAX_EDGES) : MW'(ecount_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= op_i;
      e_q  <= edge_index_i;
      u_q  <= vertex_u_i;
      v_q  <= vertex_v_i;
      x_q  <= query_vertex_i;
    end
  end

  assign status_o.is_query = (op_q == OP_QUERY);
  assign status_o.add_ok   = (e_q != '0) && (32'(e_q) <= 32'(m)) &&
                             (u_q != '0) && (32'(u_q) <= 32'(n)) &&
                             (v_q != '0) && (32'(v_q) <= 32'(n));
  assign status_o.query_ok = (x_q != '0) && (32'(x_q) <= 32'(n));

  // row read
  assign more    = (32'(rd_ptr_q) <= 32'(n));
  assign rd_fire = cmd_i.rd_en || (cmd_i.scan_step && more);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_U:    raddr = AW'(u_q - VERTEX_W'(1));
      RD_V:    raddr = AW'(v_q - VERTEX_W'(1));
      RD_X:    raddr = AW'(x_q - VERTEX_W'(1));
      RD_SCAN: raddr = AW'(rd_ptr_q - PW'(1));
      default: raddr = '0;
    endcase
  end

  // a row never written since the last clear reads as zero
  assign rrow = rvalid_q ? rdata_q : '0;

  // saturating bump of one column
  always_comb begin
    waddr = cmd_i.wr_v ? AW'(v_q - VERTEX_W'(1)) : AW'(u_q - VERTEX_W'(1));
    wcol  = EW'(e_q - EDGE_W'(1));
    wrow  = rrow;
    if (rrow[wcol] != CNT_SAT) begin
      wrow[wcol] = rrow[wcol] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      row_mem[waddr] <= wrow;
    end
    if (rd_fire) begin
      rdata_q <= row_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (cfg_clear) begin
        row_valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        row_valid_q[waddr] <= 1'b1;
      end
      if (rd_fire) begin
        rvalid_q <= row_valid_q[raddr];
      end
    end
  end

  // adjacency of the checked row against the queried row
  assign self_chk = (chk_vertex_q == x_q);

  always_comb begin
    for (int j = 0; j < MAX_EDGES; j++) begin
      hit_col[j] = self_chk ? (rrow[j] == CNT_SELF)
                            : (qrow_q[j] == CNT_ONE && rrow[j] == CNT_ONE);
    end
  end

  assign hit       = chk_valid_q && (|hit_col);
  assign out_free  = !out_valid_q || out_ready_i;
  assign push_scan = cmd_i.scan_step && hit && pend_q;

  assign status_o.scan_stall = hit && pend_q && !out_free;
  assign status_o.scan_done  = !chk_valid_q && !more;
  assign status_o.out_free   = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_qrow) begin
      qrow_q <= rrow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      chk_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (cmd_i.load_qrow) begin
        rd_ptr_q    <= PW'(1);
        chk_valid_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        chk_valid_q <= more;
        if (more) begin
          rd_ptr_q <= rd_ptr_q + PW'(1);
        end
      end
      if (cmd_i.push_final) begin
        pend_q <= 1'b0;
      end else if (cmd_i.scan_step && hit) begin
        pend_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && more) begin
      chk_vertex_q <= VERTEX_W'(rd_ptr_q);
    end
    if (cmd_i.scan_step && hit) begin
      pend_vertex_q <= chk_vertex_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_scan || cmd_i.push_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_scan) begin
      neighbour_q <= pend_vertex_q;
      found_q     <= 1'b1;
      last_q      <= 1'b0;
    end else if (cmd_i.push_final) begin
      neighbour_q <= pend_q ? pend_vertex_q : '0;
      found_q     <= pend_q;
      last_q      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign neighbour_o = neighbour_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

endmodule
